FILE: hdl/descriptor_bitstream_field_parser_assert.svh
// Assertion macros for the descriptor bitstream field parser
`ifndef DESCRIPTOR_BITSTREAM_FIELD_PARSER_ASSERT_SVH
`define DESCRIPTOR_BITSTREAM_FIELD_PARSER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define DBFP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// condition that always holds outside reset
`define DBFP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`endif

FILE: hdl/dbfp_pkg.sv
// ----------------------------------------------------------------------------
// dbfp_pkg
// Types and codes shared by the descriptor bitstream field parser.
// ----------------------------------------------------------------------------
`default_nettype none
package dbfp_pkg;
  localparam int DESC_W = 16;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    KIND_END  = 2'd0,
    KIND_UINT = 2'd1,
    KIND_BOOL = 2'd2,
    KIND_STR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_REF   = 3'd1,
    ST_MISALIGN  = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SETTLE = 5'b00010,
    S_BIT    = 5'b00100,
    S_OUT    = 5'b01000,
    S_TAIL   = 5'b10000
  } state_t;
endpackage
`default_nettype wire

FILE: hdl/descriptor_bitstream_field_parser.sv
// ----------------------------------------------------------------------------
// descriptor_bitstream_field_parser
// Splits message bytes MSB first into descriptor-defined fields.
// ----------------------------------------------------------------------------
// Each accepted byte is consumed one bit per settle/bit state pair. In the
// plain case a byte runs from its transfer in idle through a settle/bit pair
// per bit, then a settle and a tail, to the next possible transfer. Each
// field opened or skipped adds a settle pass, each result that pushes out a
// held one adds an output transfer plus any m_tready stall, and a truncation
// close adds a tail pass. Results are held one deep so that the final result
// of a byte carries m_tlast. Only one byte is in flight at a time; s_tready
// is high again once its last result is taken.
`default_nettype none
module descriptor_bitstream_field_parser #(
  parameter int NUM_FIELDS        = 8,
  parameter int VALUE_BITS        = 64,
  parameter int LENGTH_UNITS_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
  input  wire logic        s_tuser,   // message_start[0]
  input  wire logic        s_tlast,   // data_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // field_index[2:0], field_value[66:3],
                                      // status[69:67], zero[71:70]
  output logic [1:0]       m_tuser,   // is_string_byte[0], message_end[1]
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import dbfp_pkg::*;

  localparam int PW = 4;
  localparam int RW = LENGTH_UNITS_BITS + 3;

  typedef struct packed {
    status_t     st;
    logic [63:0] val;
    logic        str;
    logic        mend;
    logic [2:0]  idx;
  } result_t;

  logic [DESC_W-1:0]     desc [8];
  logic [63:0]           vals [8];
  logic                  vals_we;
  logic [63:0]           vals_wd;
  state_t                state, state_next;
  state_t                ret, ret_next;    // state after output
  logic                  aborted, aborted_next;
  logic                  active, active_next;
  kind_t                 akind, akind_next;
  logic [PW-1:0]         fp, fp_next;
  logic [7:0]            vmask, vmask_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic [RW-1:0]         rem, rem_next;
  logic [7:0]            sh, sh_next;
  logic [2:0]            k, k_next;
  logic                  nbits, nbits_next;  // still bits of the byte to consume
  logic                  dend, dend_next;
  result_t               held, held_next;    // newest result, not yet sent
  logic                  held_valid, held_valid_next;
  result_t               obuf, obuf_next;    // result on the output
  logic                  obuf_last, obuf_last_next;
  logic                  put_en;
  result_t               put_r;
  state_t                put_cont;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = (state == S_OUT);
  assign m_tdata   = {2'b00, obuf.st, obuf.val, obuf.idx};
  assign m_tuser   = {obuf.mend, obuf.str};
  assign m_tlast   = obuf_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) desc[i] <= '0;
    end else if (cfg_valid) begin
      desc[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (vals_we) vals[fp[2:0]] <= vals_wd;
  end

  // settle decode
  logic [DESC_W-1:0] d;
  kind_t             dk;
  logic [63:0]       len;
  logic [2:0]        rix;
  logic [63:0]       bits;
  logic              fp_done;
  logic              too_big;
  always_comb begin
    d       = desc[fp[2:0]];
    dk      = kind_t'(d[1:0]);
    rix     = d[6:4];
    len     = d[3] ? vals[rix] : {56'd0, d[15:8]};
    bits    = d[2] ? {len[60:0], 3'b000} : len;
    fp_done = (fp >= PW'(NUM_FIELDS));
    too_big = (len > 64'((1 << LENGTH_UNITS_BITS) - 1)) ||
              (dk == KIND_UINT && bits > 64'(VALUE_BITS));
  end

  always_comb begin
    logic [VALUE_BITS-1:0] na;
    logic [RW-1:0]         nr;
    na              = {acc[VALUE_BITS-2:0], sh[7]};
    nr              = rem - RW'(1);
    state_next      = state;
    ret_next        = ret;
    aborted_next    = aborted;
    active_next     = active;
    akind_next      = akind;
    fp_next         = fp;
    vmask_next      = vmask;
    acc_next        = acc;
    rem_next        = rem;
    sh_next         = sh;
    k_next          = k;
    nbits_next      = nbits;
    dend_next       = dend;
    held_next       = held;
    held_valid_next = held_valid;
    obuf_next       = obuf;
    obuf_last_next  = obuf_last;
    vals_we         = 1'b0;
    vals_wd         = '0;
    put_en          = 1'b0;
    put_r           = '0;
    put_r.idx       = fp[2:0];
    put_r.st        = ST_OK;
    put_cont        = S_SETTLE;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          sh_next    = s_tdata;
          dend_next  = s_tlast;
          k_next     = '0;
          nbits_next = 1'b1;
          if (s_tuser) begin
            fp_next      = '0;
            acc_next     = '0;
            rem_next     = '0;
            vmask_next   = '0;
            active_next  = 1'b0;
            aborted_next = 1'b0;
            state_next   = S_SETTLE;
          end else if (!aborted) begin
            state_next = S_SETTLE;
          end
        end
      end
      S_SETTLE: begin
        if (active) begin
          state_next = nbits ? S_BIT : S_TAIL;
        end else begin
          acc_next = '0;
          if (fp_done || dk == KIND_END) begin
            put_en = 1'b1; put_r.mend = 1'b1; put_cont = S_TAIL;
            aborted_next = 1'b1;
          end else if (d[3] && !vmask[rix]) begin
            put_en = 1'b1; put_r.mend = 1'b1; put_r.st = ST_BAD_REF;
            put_cont = S_TAIL; aborted_next = 1'b1;
          end else if (dk == KIND_BOOL) begin
            akind_next = dk; rem_next = RW'(1); active_next = 1'b1;
          end else if (dk == KIND_STR && nbits && k != 3'd0) begin
            put_en = 1'b1; put_r.mend = 1'b1; put_r.st = ST_MISALIGN;
            put_cont = S_TAIL; aborted_next = 1'b1;
          end else if (too_big) begin
            put_en = 1'b1; put_r.mend = 1'b1; put_r.st = ST_TOO_LARGE;
            put_cont = S_TAIL; aborted_next = 1'b1;
          end else if (bits == 64'd0) begin
            fp_next = fp + PW'(1);
            if (dk == KIND_UINT) begin
              vals_we = 1'b1;
              vmask_next[fp[2:0]] = 1'b1;
              put_en = 1'b1;
            end
          end else begin
            akind_next = dk; rem_next = RW'(bits); active_next = 1'b1;
          end
        end
      end
      S_BIT: begin
        sh_next    = {sh[6:0], 1'b0};
        k_next     = k + 3'd1;
        if (k == 3'd7) nbits_next = 1'b0;
        acc_next   = na;
        rem_next   = nr;
        state_next = S_SETTLE;
        if (akind == KIND_STR) begin
          if (k == 3'd7) begin
            put_en = 1'b1; put_r.val = {56'd0, na[7:0]}; put_r.str = 1'b1;
            acc_next = '0;
          end
          if (nr == '0) begin
            fp_next = fp + PW'(1); active_next = 1'b0; acc_next = '0;
          end
        end else if (nr == '0) begin
          vals_we = 1'b1; vals_wd = 64'(na);
          vmask_next[fp[2:0]] = 1'b1;
          put_en = 1'b1; put_r.val = 64'(na);
          fp_next = fp + PW'(1); active_next = 1'b0; acc_next = '0;
        end
      end
      S_TAIL: begin
        if (!aborted && dend) begin
          put_en = 1'b1; put_r.mend = 1'b1; put_r.st = ST_TRUNC;
          put_cont = S_TAIL; aborted_next = 1'b1; active_next = 1'b0;
        end else if (held_valid) begin
          obuf_next = held; obuf_last_next = 1'b1; held_valid_next = 1'b0;
          state_next = S_OUT; ret_next = S_IDLE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (m_tready) state_next = ret;
      end
      default: state_next = S_IDLE;
    endcase
    // a new result pushes the held one out; the tail sends the last as final
    if (put_en) begin
      if (held_valid) begin
        obuf_next = held; obuf_last_next = 1'b0; held_next = put_r;
        state_next = S_OUT; ret_next = put_cont;
      end else begin
        held_next = put_r; held_valid_next = 1'b1; state_next = put_cont;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      aborted    <= 1'b1;
      active     <= 1'b0;
      akind      <= KIND_END;
      fp         <= '0;
      vmask      <= '0;
      acc        <= '0;
      rem        <= '0;
      sh         <= '0;
      k          <= '0;
      nbits      <= 1'b0;
      dend       <= 1'b0;
      held       <= '0;
      held_valid <= 1'b0;
      obuf       <= '0;
      obuf_last  <= 1'b0;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      aborted    <= aborted_next;
      active     <= active_next;
      akind      <= akind_next;
      fp         <= fp_next;
      vmask      <= vmask_next;
      acc        <= acc_next;
      rem        <= rem_next;
      sh         <= sh_next;
      k          <= k_next;
      nbits      <= nbits_next;
      dend       <= dend_next;
      held       <= held_next;
      held_valid <= held_valid_next;
      obuf       <= obuf_next;
      obuf_last  <= obuf_last_next;
    end
  end

  `include "descriptor_bitstream_field_parser_assert.svh"
  `DBFP_ASSERT_IMP(a_out_hold, m_tvalid && !m_tready, state == S_OUT)
  `DBFP_ASSERT_IMP(a_no_in_busy, state != S_IDLE, !s_tready)
  `DBFP_ASSERT_IMP(a_end_last, m_tvalid && m_tuser[1], m_tlast)
endmodule
`default_nettype wire

FILE: tb/descriptor_bitstream_field_parser_tb.sv
// ----------------------------------------------------------------------------
// descriptor_bitstream_field_parser_tb
// Streams message bytes through the field parser under a series of
// descriptor sets and checks every result transfer against a predictor of
// the bit-serial field split, with random idling on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

class field_scoreboard;
  typedef struct {
    logic [2:0]  idx;
    logic [63:0] val;
    logic        str;
    logic [2:0]  st;
    logic        mend;
    logic        lst;
  } field_result_t;

  field_result_t pending[$];
  int errors;
  logic [15:0] desc[8];
  int unsigned fptr;
  logic [63:0] acc;
  longint unsigned remain;
  logic [63:0] prior[8];
  bit aborted;
  logic [7:0] vmask;
  bit active;
  dbfp_pkg::kind_t akind;
  field_result_t step_q[$];

  function new();
    errors = 0;
    foreach (desc[i]) desc[i] = '0;
    foreach (prior[i]) prior[i] = '0;
    fptr = 0; acc = '0; remain = 0; aborted = 1; vmask = '0; active = 0;
    akind = dbfp_pkg::KIND_END;
  endfunction

  function void emit(int unsigned i, logic [63:0] v, bit s, dbfp_pkg::status_t st, bit e);
    field_result_t r;
    r.idx = i[2:0]; r.val = v; r.str = s; r.st = st; r.mend = e; r.lst = 0;
    step_q = {step_q, r};
  endfunction

  function void close_msg(dbfp_pkg::status_t st);
    emit(fptr, 64'd0, 0, st, 1);
    aborted = 1; active = 0;
  endfunction

  function void take_value(logic [63:0] v);
    int unsigned i;
    i = fptr & 7;
    prior[i] = v;
    vmask[i] = 1'b1;
    emit(i, v, 0, dbfp_pkg::ST_OK, 0);
    fptr++; active = 0; acc = '0;
  endfunction

  function void open_fields(int unsigned offs);
    logic [15:0] d;
    dbfp_pkg::kind_t k;
    logic [63:0] len;
    longint unsigned bits;
    while (!aborted && !active) begin
      if (fptr >= 8) begin
        close_msg(dbfp_pkg::ST_OK);
        return;
      end
      d = desc[fptr & 7];
      k = dbfp_pkg::kind_t'(d[1:0]);
      if (k == dbfp_pkg::KIND_END) begin
        close_msg(dbfp_pkg::ST_OK);
        return;
      end
      len = 64'(d[15:8]);
      if (d[3]) begin
        if (!vmask[d[6:4]]) begin
          close_msg(dbfp_pkg::ST_BAD_REF);
          return;
        end
        len = prior[d[6:4]];
      end
      acc = '0;
      akind = k;
      if (k == dbfp_pkg::KIND_BOOL) begin
        remain = 1; active = 1;
        return;
      end
      if (k == dbfp_pkg::KIND_STR && offs != 0) begin
        close_msg(dbfp_pkg::ST_MISALIGN);
        return;
      end
      if (len > 64'd65535) begin
        close_msg(dbfp_pkg::ST_TOO_LARGE);
        return;
      end
      bits = d[2] ? len * 8 : len;
      if (k == dbfp_pkg::KIND_UINT && bits > 64) begin
        close_msg(dbfp_pkg::ST_TOO_LARGE);
        return;
      end
      if (bits == 0) begin
        if (k == dbfp_pkg::KIND_UINT) take_value(64'd0);
        else fptr++;
        continue;
      end
      remain = bits; active = 1;
    end
  endfunction

  function void note_byte(logic [7:0] b, bit start, bit dend);
    step_q.delete();
    if (start) begin
      fptr = 0; acc = '0; remain = 0; vmask = '0; active = 0; aborted = 0;
    end
    if (aborted) return;
    for (int k = 0; k < 8; k++) begin
      open_fields(k);
      if (aborted) break;
      acc = {acc[62:0], b[7-k]};
      remain--;
      if (akind == dbfp_pkg::KIND_STR) begin
        if (k == 7) begin
          emit(fptr, {56'd0, acc[7:0]}, 1, dbfp_pkg::ST_OK, 0);
          acc = '0;
        end
        if (remain == 0) begin
          fptr++; active = 0; acc = '0;
        end
      end else if (remain == 0) begin
        take_value(acc);
      end
    end
    if (!aborted) open_fields(0);
    if (!aborted && dend) close_msg(dbfp_pkg::ST_TRUNC);
    if (step_q.size() > 0) step_q[step_q.size()-1].lst = 1;
    foreach (step_q[i]) pending = {pending, step_q[i]};
  endfunction

  function void check_result(logic [71:0] td, logic [1:0] tu, logic tl);
    field_result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result tdata=%h", td);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (td[2:0] !== e.idx) begin
      $error("field_index exp %0d got %0d", e.idx, td[2:0]); errors++;
    end
    if (td[66:3] !== e.val) begin
      $error("field_val exp %h got %h", e.val, td[66:3]); errors++;
    end
    if (td[69:67] !== e.st) begin
      $error("status exp %0d got %0d", e.st, td[69:67]); errors++;
    end
    if (tu[0] !== e.str) begin
      $error("is_string_byte exp %0d got %0d", e.str, tu[0]); errors++;
    end
    if (tu[1] !== e.mend) begin
      $error("message_end exp %0d got %0d", e.mend, tu[1]); errors++;
    end
    if (tl !== e.lst) begin
      $error("last exp %0d got %0d", e.lst, tl); errors++;
    end
  endfunction
endclass

module descriptor_bitstream_field_parser_tb;
  import dbfp_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tuser = 0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [71:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  field_scoreboard fields = new();
  bit calm = 0;
  bit hold_req = 0;
  int hold_cycles = 0;

  descriptor_bitstream_field_parser dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) fields.check_result(m_tdata, m_tuser, m_tlast);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else if (hold_req) begin
      hold_cycles <= 400;
      m_tready <= 0;
    end else begin
      m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
    end
  end

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (fields.pending.size() != 0 || !s_tready) @(posedge clk);
  endtask

  task automatic write_desc(int i, logic [15:0] v);
    drain();
    cfg_valid <= 1; cfg_index <= i[2:0]; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    fields.desc[i] = v;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b, bit st, bit de);
    if (!calm && $urandom_range(99) < 31) begin
      s_tvalid <= 0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 31);
    end
    s_tvalid <= 1; s_tdata <= b; s_tuser <= st; s_tlast <= de;
    do @(posedge clk); while (!s_tready);
    fields.note_byte(b, st, de);
  endtask

  function automatic logic [15:0] rand_desc(int i);
    logic [15:0] d;
    d = 16'($urandom);
    if ($urandom_range(3) == 0) d[15:8] = 8'($urandom_range(16));
    if ($urandom_range(2) == 0) d[3] = 0;
    if (d[1:0] == KIND_END && $urandom_range(3) != 0) d[1:0] = KIND_UINT;
    if (d[3] && $urandom_range(1)) d[6:4] = 3'($urandom_range(i > 0 ? i - 1 : 0));
    return d;
  endfunction

  task automatic send_message(int n);
    for (int j = 0; j < n; j++)
      send_byte(8'($urandom), j == 0 || $urandom_range(40) == 0,
                (j == n - 1) ? 1'($urandom_range(1)) : ($urandom_range(30) == 0));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: uint 8 bits, bool, 7-bit uint, string of ref length bytes
    write_desc(0, {8'd8, 1'b0, 3'd0, 1'b0, 1'b0, KIND_UINT});
    write_desc(1, {8'd0, 1'b0, 3'd0, 1'b0, 1'b0, KIND_BOOL});
    write_desc(2, {8'd7, 1'b0, 3'd0, 1'b0, 1'b0, KIND_UINT});
    write_desc(3, {8'd0, 1'b0, 3'd2, 1'b1, 1'b1, KIND_STR});
    write_desc(4, {8'd64, 1'b0, 3'd0, 1'b0, 1'b0, KIND_UINT});
    write_desc(5, {8'd0, 1'b0, 3'd0, 1'b0, 1'b0, KIND_UINT});
    write_desc(6, {8'd8, 1'b0, 3'd0, 1'b0, 1'b1, KIND_UINT});
    write_desc(7, {8'd255, 1'b0, 3'd0, 1'b0, 1'b1, KIND_UINT});
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h81, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0);
    for (int j = 0; j < 9; j++) send_byte(8'($urandom), 1'b0, j == 8);
    send_byte(8'h00, 1'b1, 1'b1);
    drain();
    // misaligned string, bad self reference, all 8 fields used
    write_desc(0, {8'd3, 1'b0, 3'd0, 1'b0, 1'b0, KIND_UINT});
    write_desc(1, {8'd1, 1'b0, 3'd0, 1'b0, 1'b0, KIND_STR});
    send_byte(8'h5a, 1'b1, 1'b0);
    write_desc(1, {8'd0, 1'b0, 3'd1, 1'b1, 1'b0, KIND_UINT});
    drain();
    send_byte(8'hc3, 1'b1, 1'b0);
    drain();
    for (int i = 0; i < 8; i++) write_desc(i, {8'd1, 1'b0, 3'd0, 1'b0, 1'b0, KIND_BOOL});
    send_byte(8'h96, 1'b1, 1'b0);
    send_byte(8'h96, 1'b1, 1'b1);
    drain();
    // referenced lengths: long string, then an integer wider than 64 bits
    write_desc(0, {8'd2, 1'b0, 3'd0, 1'b0, 1'b1, KIND_UINT});
    write_desc(1, {8'd0, 1'b0, 3'd0, 1'b1, 1'b1, KIND_STR});
    send_byte(8'hff, 1'b1, 1'b0); send_byte(8'hff, 1'b0, 1'b0);
    write_desc(1, {8'd0, 1'b0, 3'd0, 1'b1, 1'b0, KIND_UINT});
    drain();
    send_byte(8'h00, 1'b1, 1'b0); send_byte(8'h41, 1'b0, 1'b0); send_byte(8'h00, 1'b0, 1'b1);
    drain();
    // random phases
    for (int p = 0; p < 23; p++) begin
      for (int i = 0; i < 8; i++) write_desc(i, rand_desc(i));
      calm = (p == 5);
      if (p == 9) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int j = 0; j < 6; j++) send_byte(8'($urandom), j == 0, 1'b0);
      end
      for (int m = 0; m < 4; m++) begin
        send_message($urandom_range(1, 8));
        if ($urandom_range(3) == 0) send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
      end
      drain();
    end
    calm = 0;
    if (fields.errors == 0 && fields.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #12000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
